/* rtl/core/gpiq_pkg.sv */
// shared types, register indexes and helpers for the gamepad input qualifier
`default_nettype none

package gpiq_pkg;

  localparam int AXIS_W = 16;
  localparam int DZ_W   = 15;
  localparam int TRIG_W = 8;
  localparam int BTN_W  = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_LEFT_DEADZONE  = 2'd0;
  localparam logic [1:0] CFG_RIGHT_DEADZONE = 2'd1;
  localparam logic [1:0] CFG_TRIG_THRESHOLD = 2'd2;

  // reset values of the configuration registers
  localparam logic [DZ_W-1:0]   LEFT_DZ_RESET  = 15'd7849;
  localparam logic [DZ_W-1:0]   RIGHT_DZ_RESET = 15'd8689;
  localparam logic [TRIG_W-1:0] THRESH_RESET   = 8'd30;

  // status of one stick unit
  typedef struct packed {
    logic              done;
    logic              outside;
    logic [AXIS_W-1:0] length;
  } stick_res_t;

  // started, held, released in bits 0, 1, 2
  function automatic logic [2:0] evt_bits(input logic now, input logic prev);
    evt_bits = {~now & prev, now & prev, now & ~prev};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/gpiq_if.sv */
// poll and result channel interfaces
`default_nettype none

interface gpiq_poll_if;
  import gpiq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     connected;
  logic [BTN_W-1:0]         buttons;
  logic signed [AXIS_W-1:0] left_x;
  logic signed [AXIS_W-1:0] left_y;
  logic signed [AXIS_W-1:0] right_x;
  logic signed [AXIS_W-1:0] right_y;
  logic [TRIG_W-1:0]        left_trigger;
  logic [TRIG_W-1:0]        right_trigger;

  modport source (output valid, connected, buttons, left_x, left_y, right_x, right_y,
                  left_trigger, right_trigger, input ready);
  modport sink (input valid, connected, buttons, left_x, left_y, right_x, right_y,
                left_trigger, right_trigger, output ready);
endinterface

interface gpiq_result_if;
  import gpiq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [BTN_W-1:0]         button_started_mask;
  logic [BTN_W-1:0]         button_held_mask;
  logic [BTN_W-1:0]         button_released_mask;
  logic [11:0]              analog_event_flags;
  logic [TRIG_W-1:0]        left_trigger_value;
  logic [TRIG_W-1:0]        right_trigger_value;
  logic signed [AXIS_W-1:0] left_stick_x;
  logic signed [AXIS_W-1:0] left_stick_y;
  logic [AXIS_W-1:0]        left_stick_length;
  logic signed [AXIS_W-1:0] right_stick_x;
  logic signed [AXIS_W-1:0] right_stick_y;
  logic [AXIS_W-1:0]        right_stick_length;

  modport source (output valid, button_started_mask, button_held_mask, button_released_mask,
                  analog_event_flags, left_trigger_value, right_trigger_value,
                  left_stick_x, left_stick_y, left_stick_length,
                  right_stick_x, right_stick_y, right_stick_length, input ready);
  modport sink (input valid, button_started_mask, button_held_mask, button_released_mask,
                analog_event_flags, left_trigger_value, right_trigger_value,
                left_stick_x, left_stick_y, left_stick_length,
                right_stick_x, right_stick_y, right_stick_length, output ready);
endinterface

`default_nettype wire

/* rtl/core/gpiq_stick.sv */
// one stick: bit-serial squares, deadzone compare and bit-serial floor square root
`default_nettype none

module gpiq_stick
  import gpiq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic                     take,
  input  wire logic signed [AXIS_W-1:0] x,
  input  wire logic signed [AXIS_W-1:0] y,
  input  wire logic [DZ_W-1:0]          dz,
  output stick_res_t                    res
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]          state;
  logic [3:0]          cnt;
  logic [AXIS_W-1:0]   ax, ay, adz;
  logic [2*AXIS_W-1:0] px, py, pd;
  logic [2*AXIS_W-1:0] mag;
  logic [2*AXIS_W-1:0] rad;
  logic                outside;
  logic [AXIS_W+1:0]   rem;
  logic [AXIS_W-1:0]   root;

  logic [AXIS_W:0]     sum_x, sum_y, sum_d;
  logic [AXIS_W+3:0]   rem_sh, trial;
  logic                fits;

  // shift-add step: add multiplicand into the upper half when the low bit is set
  assign sum_x = {1'b0, px[2*AXIS_W-1:AXIS_W]} + (px[0] ? {1'b0, ax}  : '0);
  assign sum_y = {1'b0, py[2*AXIS_W-1:AXIS_W]} + (py[0] ? {1'b0, ay}  : '0);
  assign sum_d = {1'b0, pd[2*AXIS_W-1:AXIS_W]} + (pd[0] ? {1'b0, adz} : '0);

  // restoring root step, two radicand bits per cycle
  assign rem_sh = {rem, rad[2*AXIS_W-1:2*AXIS_W-2]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_MUL;
            cnt   <= '0;
          end
        end
        ST_MUL: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= ST_SUM;
        end
        ST_SUM: state <= ST_CMP;
        ST_CMP: begin
          state <= ST_SQRT;
          cnt   <= '0;
        end
        ST_SQRT: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= ST_DONE;
        end
        ST_DONE: begin
          if (take) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          ax  <= x[AXIS_W-1] ? AXIS_W'(~x + 1'b1) : AXIS_W'(x);
          ay  <= y[AXIS_W-1] ? AXIS_W'(~y + 1'b1) : AXIS_W'(y);
          adz <= {1'b0, dz};
          px  <= {{AXIS_W{1'b0}}, (x[AXIS_W-1] ? AXIS_W'(~x + 1'b1) : AXIS_W'(x))};
          py  <= {{AXIS_W{1'b0}}, (y[AXIS_W-1] ? AXIS_W'(~y + 1'b1) : AXIS_W'(y))};
          pd  <= {{AXIS_W{1'b0}}, 1'b0, dz};
        end
      end
      ST_MUL: begin
        px <= {sum_x, px[AXIS_W-1:1]};
        py <= {sum_y, py[AXIS_W-1:1]};
        pd <= {sum_d, pd[AXIS_W-1:1]};
      end
      ST_SUM: mag <= px + py;
      ST_CMP: begin
        outside <= mag > pd;
        rad     <= mag;
        rem     <= '0;
        root    <= '0;
      end
      ST_SQRT: begin
        rem  <= fits ? (AXIS_W+2)'(rem_sh - trial) : (AXIS_W+2)'(rem_sh);
        root <= {root[AXIS_W-2:0], fits};
        rad  <= {rad[2*AXIS_W-3:0], 2'b00};
      end
      default: ;
    endcase
  end

  assign res.done    = (state == ST_DONE);
  assign res.outside = outside;
  assign res.length  = root;

endmodule

`default_nettype wire

/* rtl/core/gamepad_input_qualifier.sv */
// top level: poll capture, edge state, trigger test and result register
//
//  channel  dir  handshake      payload
//  poll     in   valid/ready    connected, buttons, stick axes, triggers
//  result   out  valid/ready    button masks, event flags, qualified values
//  cfg      in   cfg_we only    cfg_index, cfg_data
//
// one poll runs from acceptance to result through bit-serial squaring, the sum and
// deadzone compare, bit-serial root and the load into the result register; both
// sticks run side by side
// the next poll is taken once the previous result sits in the result register
// a result stalled at the output holds the next one back in the stick units
// rst is synchronous: history clears to zero, registers take their reset values
`default_nettype none

module gamepad_input_qualifier
  import gpiq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  gpiq_poll_if.sink              poll,
  gpiq_result_if.source          result,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [DZ_W-1:0]   cfg_data
);

  logic [DZ_W-1:0]   left_dz, right_dz;
  logic [TRIG_W-1:0] thresh;

  logic [BTN_W-1:0]  prev_btn;
  logic [1:0]        prev_trig;
  logic [1:0]        prev_stick;

  logic                     busy;
  logic [BTN_W-1:0]         btn;
  logic signed [AXIS_W-1:0] lx, ly, rx, ry;
  logic [TRIG_W-1:0]        lt, rt;

  logic                     out_valid;
  logic [BTN_W-1:0]         started, held, released;
  logic [11:0]              flags;
  logic [TRIG_W-1:0]        lt_val, rt_val;
  logic signed [AXIS_W-1:0] lsx, lsy, rsx, rsy;
  logic [AXIS_W-1:0]        llen, rlen;

  logic accept, load, ltd, rtd;
  logic signed [AXIS_W-1:0] in_lx, in_ly, in_rx, in_ry;
  stick_res_t res_l, res_r;

  // no poll is taken while reset is held
  assign poll.ready = !busy && !rst;
  assign accept     = poll.valid && poll.ready;

  // a disconnected poll counts as all zeros
  assign in_lx = poll.connected ? poll.left_x  : '0;
  assign in_ly = poll.connected ? poll.left_y  : '0;
  assign in_rx = poll.connected ? poll.right_x : '0;
  assign in_ry = poll.connected ? poll.right_y : '0;

  assign load = busy && res_l.done && res_r.done && (!out_valid || result.ready);
  assign ltd  = lt >= thresh;
  assign rtd  = rt >= thresh;

  gpiq_stick u_left (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .take  (load),
    .x     (in_lx),
    .y     (in_ly),
    .dz    (left_dz),
    .res   (res_l)
  );

  gpiq_stick u_right (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .take  (load),
    .x     (in_rx),
    .y     (in_ry),
    .dz    (right_dz),
    .res   (res_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz  <= LEFT_DZ_RESET;
      right_dz <= RIGHT_DZ_RESET;
      thresh   <= THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT_DEADZONE:  left_dz  <= cfg_data;
        CFG_RIGHT_DEADZONE: right_dz <= cfg_data;
        CFG_TRIG_THRESHOLD: thresh   <= cfg_data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      out_valid  <= 1'b0;
      prev_btn   <= '0;
      prev_trig  <= '0;
      prev_stick <= '0;
    end else begin
      if (accept) busy <= 1'b1;
      else if (load) busy <= 1'b0;

      if (load) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;

      if (load) begin
        prev_btn   <= btn;
        prev_trig  <= {rtd, ltd};
        prev_stick <= {res_r.outside, res_l.outside};
      end
    end
  end

  // poll capture
  always_ff @(posedge clk) begin
    if (accept) begin
      btn <= poll.connected ? poll.buttons : '0;
      lx  <= in_lx;
      ly  <= in_ly;
      rx  <= in_rx;
      ry  <= in_ry;
      lt  <= poll.connected ? poll.left_trigger  : '0;
      rt  <= poll.connected ? poll.right_trigger : '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      started  <= btn & ~prev_btn;
      held     <= btn & prev_btn;
      released <= ~btn & prev_btn;
      flags    <= {evt_bits(res_r.outside, prev_stick[1]),
                   evt_bits(res_l.outside, prev_stick[0]),
                   evt_bits(rtd, prev_trig[1]),
                   evt_bits(ltd, prev_trig[0])};
      lt_val   <= ltd ? lt : '0;
      rt_val   <= rtd ? rt : '0;
      lsx      <= res_l.outside ? lx : '0;
      lsy      <= res_l.outside ? ly : '0;
      llen     <= res_l.outside ? res_l.length : '0;
      rsx      <= res_r.outside ? rx : '0;
      rsy      <= res_r.outside ? ry : '0;
      rlen     <= res_r.outside ? res_r.length : '0;
    end
  end

  assign result.valid                = out_valid;
  assign result.button_started_mask  = started;
  assign result.button_held_mask     = held;
  assign result.button_released_mask = released;
  assign result.analog_event_flags   = flags;
  assign result.left_trigger_value   = lt_val;
  assign result.right_trigger_value  = rt_val;
  assign result.left_stick_x         = lsx;
  assign result.left_stick_y         = lsy;
  assign result.left_stick_length    = llen;
  assign result.right_stick_x        = rsx;
  assign result.right_stick_y        = rsy;
  assign result.right_stick_length   = rlen;

endmodule

`default_nettype wire

/* bench/gamepad_input_qualifier_tb.sv */
// self-checking testbench for the gamepad input qualifier: edges, triggers and stick deadzones
`default_nettype none

module gamepad_input_qualifier_tb;
  import gpiq_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    logic                     connected;
    logic [BTN_W-1:0]         buttons;
    logic signed [AXIS_W-1:0] lx;
    logic signed [AXIS_W-1:0] ly;
    logic signed [AXIS_W-1:0] rx;
    logic signed [AXIS_W-1:0] ry;
    logic [TRIG_W-1:0]        lt;
    logic [TRIG_W-1:0]        rt;
  } poll_t;

  typedef struct {
    logic [BTN_W-1:0]         started;
    logic [BTN_W-1:0]         held;
    logic [BTN_W-1:0]         released;
    logic [11:0]              flags;
    logic [TRIG_W-1:0]        lt_val;
    logic [TRIG_W-1:0]        rt_val;
    logic signed [AXIS_W-1:0] lx;
    logic signed [AXIS_W-1:0] ly;
    logic [AXIS_W-1:0]        llen;
    logic signed [AXIS_W-1:0] rx;
    logic signed [AXIS_W-1:0] ry;
    logic [AXIS_W-1:0]        rlen;
  } qual_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [DZ_W-1:0] cfg_data;

  gpiq_poll_if   poll_ch ();
  gpiq_result_if res_ch ();

  gamepad_input_qualifier dut (
    .clk       (clk),
    .rst       (rst),
    .poll      (poll_ch.sink),
    .result    (res_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies and edge history of the predictor
  logic [DZ_W-1:0]   dz_left   = LEFT_DZ_RESET;
  logic [DZ_W-1:0]   dz_right  = RIGHT_DZ_RESET;
  logic [TRIG_W-1:0] threshold = THRESH_RESET;
  logic [BTN_W-1:0]  last_buttons = '0;
  logic [1:0]        last_outside = '0;
  logic [1:0]        last_down    = '0;

  poll_t polls_waiting[$];
  qual_t results_due[$];

  logic [BTN_W-1:0] gen_buttons = '0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit pressure_on = 0;
  bit pressure_done = 0;
  int hold_count = 0;
  int mismatches = 0;
  int polls_sent = 0;
  int results_checked = 0;
  int settings_used = 1;
  int quiet_cycles = 0;

  function automatic logic [15:0] floor_sqrt(longint unsigned m);
    longint unsigned r, t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= m) r = t;
    end
    return r[15:0];
  endfunction

  function automatic void judge_stick(input logic signed [AXIS_W-1:0] x, y,
                                      input logic [DZ_W-1:0] radius, output logic outside,
                                      output logic signed [AXIS_W-1:0] ox, oy,
                                      output logic [AXIS_W-1:0] len);
    longint unsigned mag, lim;
    mag = longint'(x) * longint'(x) + longint'(y) * longint'(y);
    lim = longint'(radius) * longint'(radius);
    outside = mag > lim;
    ox  = outside ? x : '0;
    oy  = outside ? y : '0;
    len = outside ? floor_sqrt(mag) : '0;
  endfunction

  // started, held, released from low bit up
  function automatic logic [2:0] transitions(logic now, logic was);
    return {was & ~now, was & now, now & ~was};
  endfunction

  function automatic qual_t qualify_poll(poll_t p);
    qual_t q;
    logic [BTN_W-1:0] btn;
    logic signed [AXIS_W-1:0] lx, ly, rx, ry;
    logic [TRIG_W-1:0] lt, rt;
    logic ltd, rtd, lso, rso;
    btn = p.connected ? p.buttons : '0;
    lx  = p.connected ? p.lx : '0;
    ly  = p.connected ? p.ly : '0;
    rx  = p.connected ? p.rx : '0;
    ry  = p.connected ? p.ry : '0;
    lt  = p.connected ? p.lt : '0;
    rt  = p.connected ? p.rt : '0;
    ltd = lt >= threshold;
    rtd = rt >= threshold;
    judge_stick(lx, ly, dz_left, lso, q.lx, q.ly, q.llen);
    judge_stick(rx, ry, dz_right, rso, q.rx, q.ry, q.rlen);
    q.started  = btn & ~last_buttons;
    q.held     = btn & last_buttons;
    q.released = ~btn & last_buttons;
    q.flags = {transitions(rso, last_outside[1]), transitions(lso, last_outside[0]),
               transitions(rtd, last_down[1]), transitions(ltd, last_down[0])};
    q.lt_val = ltd ? lt : '0;
    q.rt_val = rtd ? rt : '0;
    last_buttons = btn;
    last_down    = {rtd, ltd};
    last_outside = {rso, lso};
    return q;
  endfunction

  function automatic poll_t mk_poll(bit c, int btn, int lx, int ly, int rx, int ry,
                                    int lt, int rt);
    poll_t p;
    p.connected = c;
    p.buttons   = 16'(btn);
    p.lx = 16'(lx);
    p.ly = 16'(ly);
    p.rx = 16'(rx);
    p.ry = 16'(ry);
    p.lt = 8'(lt);
    p.rt = 8'(rt);
    return p;
  endfunction

  function automatic int axis_extreme();
    case ($urandom_range(3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic void random_stick(input logic [DZ_W-1:0] radius,
                                       output logic signed [AXIS_W-1:0] x, y);
    int a, b, t;
    case ($urandom_range(3))
      0: begin
        a = $urandom;
        b = $urandom;
      end
      1: begin
        // on, just inside or just past the rim of the deadzone
        a = $urandom_range(0, radius);
        b = int'(floor_sqrt(longint'(radius) * radius - longint'(a) * a)) + $urandom_range(1);
        if (b > 32767) b = 32767;
        if ($urandom_range(1)) a = -a;
        if ($urandom_range(1)) b = -b;
        if ($urandom_range(1)) begin
          t = a;
          a = b;
          b = t;
        end
      end
      2: begin
        a = int'($urandom_range(2000)) - 1000;
        b = int'($urandom_range(2000)) - 1000;
      end
      default: begin
        a = axis_extreme();
        b = axis_extreme();
      end
    endcase
    x = 16'(a);
    y = 16'(b);
  endfunction

  function automatic logic [TRIG_W-1:0] random_trigger();
    int t;
    if ($urandom_range(2) == 0) return 8'($urandom);
    t = int'(threshold) + int'($urandom_range(2)) - 1;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  function automatic poll_t random_poll();
    poll_t p;
    p.connected = $urandom_range(99) < 92;
    if ($urandom_range(2) == 0) p.buttons = 16'($urandom);
    else p.buttons = gen_buttons ^ (16'($urandom) & 16'($urandom) & 16'($urandom));
    gen_buttons = p.buttons;
    random_stick(dz_left, p.lx, p.ly);
    random_stick(dz_right, p.rx, p.ry);
    p.lt = random_trigger();
    p.rt = random_trigger();
    return p;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("mismatch on result %0d, %s: expected %h, got %h",
                 results_checked, name, want, got);
      mismatches++;
    end
  endtask

  // writes all three registers back to back, stray high bits on the threshold
  task automatic set_regs(int left, int right, int thr);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LEFT_DEADZONE;
    cfg_data  <= 15'(left);
    dz_left = 15'(left);
    @(posedge clk);
    cfg_index <= CFG_RIGHT_DEADZONE;
    cfg_data  <= 15'(right);
    dz_right = 15'(right);
    @(posedge clk);
    cfg_index <= CFG_TRIG_THRESHOLD;
    cfg_data  <= {7'($urandom), 8'(thr)};
    threshold = 8'(thr);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(int n, int idle_pct, int stall_pct);
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) polls_waiting.push_back(random_poll());
    while (polls_waiting.size() != 0 || results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_LEFT_DEADZONE;
    cfg_data = '0;
    poll_ch.valid = 1'b0;
    poll_ch.connected = 1'b0;
    poll_ch.buttons = '0;
    poll_ch.left_x = '0;
    poll_ch.left_y = '0;
    poll_ch.right_x = '0;
    poll_ch.right_y = '0;
    poll_ch.left_trigger = '0;
    poll_ch.right_trigger = '0;
    res_ch.ready = 1'b0;
    forever #1 clk = ~clk;
  end

  // poll driver
  always @(posedge clk) begin : drive_polls
    poll_t p;
    bit taken;
    if (rst) begin
      poll_ch.valid <= 1'b0;
    end else begin
      taken = poll_ch.valid && poll_ch.ready;
      if (taken) begin
        results_due.push_back(qualify_poll(polls_waiting.pop_front()));
        polls_sent++;
      end
      if (!poll_ch.valid || taken) begin
        if (polls_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          p = polls_waiting[0];
          poll_ch.valid         <= 1'b1;
          poll_ch.connected     <= p.connected;
          poll_ch.buttons       <= p.buttons;
          poll_ch.left_x        <= p.lx;
          poll_ch.left_y        <= p.ly;
          poll_ch.right_x       <= p.rx;
          poll_ch.right_y       <= p.ry;
          poll_ch.left_trigger  <= p.lt;
          poll_ch.right_trigger <= p.rt;
        end else begin
          poll_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin : watch_results
    qual_t want;
    bit holding;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (results_due.size() == 0) begin
          if (mismatches < 10) $display("result with no poll waiting for it");
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("button_started_mask", want.started, res_ch.button_started_mask);
          check_field("button_held_mask", want.held, res_ch.button_held_mask);
          check_field("button_released_mask", want.released, res_ch.button_released_mask);
          check_field("analog_event_flags", 16'(want.flags), 16'(res_ch.analog_event_flags));
          check_field("left_trigger_value", 16'(want.lt_val), 16'(res_ch.left_trigger_value));
          check_field("right_trigger_value", 16'(want.rt_val),
                      16'(res_ch.right_trigger_value));
          check_field("left_stick_x", want.lx, res_ch.left_stick_x);
          check_field("left_stick_y", want.ly, res_ch.left_stick_y);
          check_field("left_stick_length", want.llen, res_ch.left_stick_length);
          check_field("right_stick_x", want.rx, res_ch.right_stick_x);
          check_field("right_stick_y", want.ry, res_ch.right_stick_y);
          check_field("right_stick_length", want.rlen, res_ch.right_stick_length);
        end
        results_checked++;
      end
      // long hold-off so the block backs up into the poll channel
      holding = pressure_on && !pressure_done;
      if (holding) begin
        hold_count++;
        if (hold_count >= HOLD_CYCLES) pressure_done = 1'b1;
      end
      res_ch.ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((poll_ch.valid && poll_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (polls_waiting.size() == 0 && results_due.size() == 0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset register values: edges, rims, disconnect and extremes
    @(negedge clk);
    polls_waiting.push_back(mk_poll(1, 'h0000, 0, 0, 0, 0, 0, 0));
    polls_waiting.push_back(mk_poll(1, 'hFFFF, 32767, 32767, -32768, -32768, 255, 255));
    polls_waiting.push_back(mk_poll(1, 'hFFFF, 32767, 32767, -32768, -32768, 255, 255));
    polls_waiting.push_back(mk_poll(0, 'hFFFF, 32767, 32767, -32768, -32768, 255, 255));
    polls_waiting.push_back(mk_poll(1, 'hA5A5, 7849, 0, 0, -8689, 29, 30));
    polls_waiting.push_back(mk_poll(1, 'h5A5A, 7850, 0, 0, -8690, 30, 29));
    polls_waiting.push_back(mk_poll(1, 'h5A5A, -5550, -5550, 6144, 6144, 31, 0));
    polls_waiting.push_back(mk_poll(1, 'h0000, -32768, -32768, -32768, 32767, 0, 255));
    polls_waiting.push_back(mk_poll(1, 'h0001, 1, -1, 32767, -32768, 128, 128));
    polls_waiting.push_back(mk_poll(0, 'h0000, 0, 0, 0, 0, 0, 0));
    polls_waiting.push_back(mk_poll(1, 'h8000, -7849, 0, 0, 8689, 30, 30));
    run_phase(20, 0, 0);

    // zero deadzones and zero threshold: triggers count as down even when disconnected
    set_regs(0, 0, 0);
    @(negedge clk);
    polls_waiting.push_back(mk_poll(0, 'h1234, 100, 100, -100, -100, 7, 7));
    polls_waiting.push_back(mk_poll(1, 'h0000, 0, 0, 0, 0, 0, 0));
    polls_waiting.push_back(mk_poll(1, 'h00FF, 1, 0, 0, -1, 0, 0));
    polls_waiting.push_back(mk_poll(0, 'h0000, 0, 0, 0, 0, 0, 0));
    run_phase(60, 0, 0);

    // widest deadzones and top threshold
    set_regs(32767, 32767, 255);
    @(negedge clk);
    polls_waiting.push_back(mk_poll(1, 'hFF00, 32767, 1, -32768, 0, 254, 255));
    polls_waiting.push_back(mk_poll(1, 'h0FF0, 32767, 0, 0, -32767, 255, 254));
    polls_waiting.push_back(mk_poll(1, 'hF00F, -32768, -32768, 23170, 23170, 255, 255));
    run_phase(90, 66, 0);

    // receiver stalls, with one long hold-off while polls keep coming
    set_regs($urandom_range(2000, 12000), $urandom_range(2000, 12000), $urandom_range(255));
    @(negedge clk);
    pressure_on = 1'b1;
    run_phase(100, 0, 66);

    set_regs(LEFT_DZ_RESET, RIGHT_DZ_RESET, THRESH_RESET);
    run_phase(100, 35, 35);

    set_regs($urandom_range(32767), $urandom_range(1000, 9000), $urandom_range(1, 254));
    run_phase(100, 35, 35);

    $display("%0d polls sent, %0d results checked over %0d register settings,",
             polls_sent, results_checked, settings_used);
    $display("including zero and full deadzones, thresholds 0 and 255, and a long output stall");
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, results_due.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
